// ===== rtl/bbm_pkg.sv =====
// shared types, constants and helpers of the binary boundary marker
package bbm_pkg;

  // default frame limits
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  // field widths
  localparam int PIX_W     = 8;
  localparam int ROW_OUT_W = 12;
  localparam int COL_OUT_W = 11;
  localparam int CFG_W_W   = 12;
  localparam int CFG_H_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // register reset values
  localparam logic [CFG_W_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
  localparam logic [CFG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  // red levels
  localparam logic [PIX_W-1:0] RED_FULL = 8'hFF;
  localparam logic [PIX_W-1:0] RED_ZERO = 8'h00;

  // two-bit pixel classes
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_OTHER = 2'd0;
  localparam cls_t CLS_ZERO  = 2'd1;
  localparam cls_t CLS_FULL  = 2'd2;

  // line buffer entry: {two rows up, one row up}
  localparam int LB_W = 4;

  // result queue depth
  localparam int FIFO_DEPTH = 4;

  // pixel moving from the counters into the window stage
  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic [PIX_W-1:0]     alpha;
    cls_t                 cls;
    logic                 emit_int;
    logic                 border;
    logic                 col0_in;
    logic                 col2_in;
    logic                 row0_in;
    logic                 row2_in;
  } pix_item_t;

  // one emitted result
  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [PIX_W-1:0]     red;
    logic [PIX_W-1:0]     green;
    logic [PIX_W-1:0]     blue;
    logic [PIX_W-1:0]     alpha;
    logic                 last;
  } result_t;

  // up to two results caused by one pixel
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } res_pair_t;

  // window stage status
  typedef struct packed {
    logic vld;
    logic adv;
  } core_stat_t;

  // red value to class
  function automatic cls_t classify(input logic [PIX_W-1:0] red);
    cls_t c;
    if (red == RED_FULL) c = CLS_FULL;
    else if (red == RED_ZERO) c = CLS_ZERO;
    else c = CLS_OTHER;
    return c;
  endfunction

endpackage

// ===== rtl/bbm_line_buf.sv =====
// two-row class line buffer with read-modify-write forwarding
module bbm_line_buf #(
  parameter int DEPTH = bbm_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [bbm_pkg::LB_W-1:0]  rd_data,
  input  logic                      wr_en,
  input  logic [bbm_pkg::LB_W-1:0]  wr_data
);

  localparam int AW = $clog2(DEPTH);

  logic [bbm_pkg::LB_W-1:0] mem [DEPTH];
  logic [bbm_pkg::LB_W-1:0] q_r;
  logic [AW-1:0]            addr_r;
  logic                     fwd_r;
  logic [bbm_pkg::LB_W-1:0] fwd_data_r;

  // storage: write goes to the column last read
  always_ff @(posedge clk) begin
    if (wr_en) mem[addr_r] <= wr_data;
    if (rd_en) q_r <= mem[rd_addr];
  end

  // address and forward capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (rd_addr == addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_r     <= rd_addr;
      fwd_data_r <= wr_data;
    end
  end

  // same-column write in the read cycle wins
  assign rd_data = fwd_r ? fwd_data_r : q_r;

endmodule

// ===== rtl/bbm_edge_core.sv =====
// window stage: 3x3 class window, edge decision and result forming
module bbm_edge_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  bbm_pkg::pix_item_t        item_in,
  input  logic [bbm_pkg::LB_W-1:0]  lb_rd_data,
  input  logic                      room,
  output logic [bbm_pkg::LB_W-1:0]  lb_wr_data,
  output bbm_pkg::res_pair_t        pair,
  output bbm_pkg::core_stat_t       stat
);

  bbm_pkg::pix_item_t item_r;
  logic               vld_r;
  logic               vld_nxt;
  logic [11:0]        win_r;
  logic [11:0]        win_nxt;
  logic               adv;
  bbm_pkg::cls_t      cls_u;
  bbm_pkg::cls_t      cls_m;
  logic [5:0]         cur;
  logic [5:0]         col1;
  logic [5:0]         col2;
  logic               zero_any;
  logic               edge_hit;
  bbm_pkg::result_t   int_res;
  bbm_pkg::result_t   brd_res;

  assign adv = vld_r && room;

  // stage register
  always_comb begin
    vld_nxt = load || (vld_r && !adv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) item_r <= item_in;
  end

  // current column of the window
  assign cls_u = lb_rd_data[3:2];
  assign cls_m = lb_rd_data[1:0];
  assign cur   = {item_r.cls, cls_m, cls_u};
  assign col1  = win_r[5:0];
  assign col2  = win_r[11:6];

  // any interior neighbor at red zero
  always_comb begin
    zero_any = 1'b0;
    if (item_r.row0_in && col1[1:0] == bbm_pkg::CLS_ZERO) zero_any = 1'b1;
    if (item_r.row2_in && col1[5:4] == bbm_pkg::CLS_ZERO) zero_any = 1'b1;
    if (item_r.col0_in) begin
      if (item_r.row0_in && cur[1:0] == bbm_pkg::CLS_ZERO) zero_any = 1'b1;
      if (cur[3:2] == bbm_pkg::CLS_ZERO) zero_any = 1'b1;
      if (item_r.row2_in && cur[5:4] == bbm_pkg::CLS_ZERO) zero_any = 1'b1;
    end
    if (item_r.col2_in) begin
      if (item_r.row0_in && col2[1:0] == bbm_pkg::CLS_ZERO) zero_any = 1'b1;
      if (col2[3:2] == bbm_pkg::CLS_ZERO) zero_any = 1'b1;
      if (item_r.row2_in && col2[5:4] == bbm_pkg::CLS_ZERO) zero_any = 1'b1;
    end
    edge_hit = (col1[3:2] == bbm_pkg::CLS_FULL) && zero_any;
  end

  // interior result one row and one column back
  always_comb begin
    int_res.row   = item_r.row - bbm_pkg::ROW_OUT_W'(1);
    int_res.col   = item_r.col - bbm_pkg::COL_OUT_W'(1);
    int_res.red   = edge_hit ? bbm_pkg::RED_FULL : bbm_pkg::RED_ZERO;
    int_res.green = bbm_pkg::RED_ZERO;
    int_res.blue  = bbm_pkg::RED_ZERO;
    int_res.alpha = bbm_pkg::RED_FULL;
    int_res.last  = !item_r.border;
  end

  // border pixel passes through
  always_comb begin
    brd_res.row   = item_r.row;
    brd_res.col   = item_r.col;
    brd_res.red   = item_r.red;
    brd_res.green = item_r.green;
    brd_res.blue  = item_r.blue;
    brd_res.alpha = item_r.alpha;
    brd_res.last  = 1'b1;
  end

  // result pair toward the queue
  always_comb begin
    pair.cnt    = {1'b0, item_r.emit_int} + {1'b0, item_r.border};
    pair.first  = item_r.emit_int ? int_res : brd_res;
    pair.second = brd_res;
  end

  // window shift
  always_comb begin
    win_nxt = {col1, cur};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (adv) begin
      win_r <= win_nxt;
    end
  end

  assign lb_wr_data = {cls_m, item_r.cls};
  assign stat.vld   = vld_r;
  assign stat.adv   = adv;

endmodule

// ===== rtl/bbm_result_fifo.sv =====
// small result queue taking up to two results per beat
module bbm_result_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bbm_pkg::res_pair_t  pair,
  input  logic                pop,
  output logic                out_vld,
  output bbm_pkg::result_t    head,
  output logic                room
);

  localparam int D  = bbm_pkg::FIFO_DEPTH;
  localparam int PW = $clog2(D);
  localparam int CW = $clog2(D + 1);

  bbm_pkg::result_t ent_r [D];
  logic [PW-1:0]    wp_r;
  logic [PW-1:0]    wp_nxt;
  logic [PW-1:0]    rp_r;
  logic [PW-1:0]    rp_nxt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    cnt_nxt;
  logic [1:0]       n_in;
  logic             do_pop;

  assign n_in   = push ? pair.cnt : 2'd0;
  assign do_pop = pop && out_vld;

  // pointers and fill level
  always_comb begin
    wp_nxt  = wp_r + PW'(n_in);
    rp_nxt  = rp_r + PW'(do_pop);
    cnt_nxt = cnt_r + CW'(n_in) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (n_in != 2'd0) ent_r[wp_r] <= pair.first;
    if (n_in == 2'd2) ent_r[wp_r + PW'(1)] <= pair.second;
  end

  assign out_vld = (cnt_r != '0);
  assign head    = ent_r[rp_r];
  assign room    = (cnt_r <= CW'(D - 2));

endmodule

// ===== rtl/binary_boundary_marker_3x3.sv =====
// top level of the binary boundary marker with raster counters and configuration
//
// Pixels enter in raster order on the in_ channel, one beat per pixel, with
// in_frame_start marking the first pixel of a frame. Results leave on the out_
// channel with their row and column; out_last_of_run closes the results of one
// pixel. Border pixels pass through as they arrive; an interior pixel leaves
// when the pixel one row and one column past it enters, as opaque red for an
// edge and opaque black otherwise.
// Throughput is one pixel per cycle while the queue has room, set by the line
// buffer read-modify-write that runs once per pixel. Results leave at one per
// cycle while out_ready is high; on the bottom row each pixel from column 2 on
// causes two, so there the input is held back whenever the queue lacks room.
// The second result at the right border column can likewise stall the input.
// An accepted beat is registered in the window stage, and its results are then
// written into the queue, from whose head they leave on the out_ channel.
// The cfg_ channel writes image_width (index 0) and image_height (index 1)
// and is always ready; write only while idle.
// Reset clears counters, window and queue and sets 640 by 480; the line buffer
// is not cleared. When out_ready is low the queue fills and in_ready drops,
// with nothing lost.
module binary_boundary_marker_3x3 #(
  parameter int MAX_WIDTH  = bbm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbm_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bbm_pkg::PIX_W-1:0]         in_red,
  input  logic [bbm_pkg::PIX_W-1:0]         in_green,
  input  logic [bbm_pkg::PIX_W-1:0]         in_blue,
  input  logic [bbm_pkg::PIX_W-1:0]         in_alpha,
  input  logic                              in_frame_start,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bbm_pkg::ROW_OUT_W-1:0]     out_pixel_row,
  output logic [bbm_pkg::COL_OUT_W-1:0]     out_pixel_column,
  output logic [bbm_pkg::PIX_W-1:0]         out_red,
  output logic [bbm_pkg::PIX_W-1:0]         out_green,
  output logic [bbm_pkg::PIX_W-1:0]         out_blue,
  output logic [bbm_pkg::PIX_W-1:0]         out_alpha,
  output logic                              out_last_of_run,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [bbm_pkg::CFG_W_W-1:0] width_r;
  logic [bbm_pkg::CFG_H_W-1:0] height_r;
  logic [WW-1:0]               w_eff;
  logic [HW-1:0]               h_eff;
  logic [WW:0]                 wx;
  logic [HW:0]                 hx;
  logic [CW-1:0]               col_r;
  logic [CW-1:0]               col_nxt;
  logic [RW-1:0]               row_r;
  logic [RW-1:0]               row_nxt;
  logic [CW-1:0]               c_cur;
  logic [RW-1:0]               r_cur;
  logic [WW:0]                 cx;
  logic [HW:0]                 rx;
  logic                        acc;
  bbm_pkg::pix_item_t          item;
  logic [bbm_pkg::LB_W-1:0]    lb_rd_data;
  logic [bbm_pkg::LB_W-1:0]    lb_wr_data;
  bbm_pkg::res_pair_t          pair;
  bbm_pkg::core_stat_t         core_stat;
  bbm_pkg::result_t            head;
  logic                        fifo_room;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bbm_pkg::IMAGE_WIDTH_RST;
      height_r <= bbm_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bbm_pkg::REG_IMAGE_WIDTH: width_r <= cfg_data[bbm_pkg::CFG_W_W-1:0];
        bbm_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data[bbm_pkg::CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  always_comb begin
    if (width_r == '0) w_eff = WW'(1);
    else if (int'(width_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_r);
    if (height_r == '0) h_eff = HW'(1);
    else if (int'(height_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_r);
    wx = (WW + 1)'(w_eff);
    hx = (HW + 1)'(h_eff);
  end

  // input handshake
  assign in_ready = !core_stat.vld || core_stat.adv;
  assign acc      = in_valid && in_ready;

  // position of the arriving pixel
  always_comb begin
    c_cur = col_r;
    r_cur = row_r;
    if (in_frame_start) begin
      c_cur = '0;
      r_cur = '0;
    end
    if ((WW + 1)'(c_cur) >= wx) c_cur = '0;
    if ((HW + 1)'(r_cur) >= hx) r_cur = '0;
    cx = (WW + 1)'(c_cur);
    rx = (HW + 1)'(r_cur);
  end

  // raster advance
  always_comb begin
    col_nxt = c_cur + CW'(1);
    row_nxt = r_cur;
    if (cx + (WW + 1)'(1) >= wx) begin
      col_nxt = '0;
      row_nxt = (rx + (HW + 1)'(1) >= hx) ? '0 : r_cur + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // pixel item with window flags
  always_comb begin
    item.row      = bbm_pkg::ROW_OUT_W'(r_cur);
    item.col      = bbm_pkg::COL_OUT_W'(c_cur);
    item.red      = in_red;
    item.green    = in_green;
    item.blue     = in_blue;
    item.alpha    = in_alpha;
    item.cls      = bbm_pkg::classify(in_red);
    item.emit_int = (rx >= (HW + 1)'(2)) && (cx >= (WW + 1)'(2));
    item.border   = (rx == '0) || (cx == '0) || (rx + (HW + 1)'(1) == hx) ||
                    (cx + (WW + 1)'(1) == wx);
    item.col0_in  = (cx + (WW + 1)'(2) <= wx);
    item.col2_in  = (cx >= (WW + 1)'(3));
    item.row0_in  = (rx >= (HW + 1)'(3));
    item.row2_in  = (rx + (HW + 1)'(2) <= hx);
  end

  bbm_line_buf #(
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_addr (c_cur),
    .rd_data (lb_rd_data),
    .wr_en   (core_stat.adv),
    .wr_data (lb_wr_data)
  );

  bbm_edge_core u_edge_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (acc),
    .item_in    (item),
    .lb_rd_data (lb_rd_data),
    .room       (fifo_room),
    .lb_wr_data (lb_wr_data),
    .pair       (pair),
    .stat       (core_stat)
  );

  bbm_result_fifo u_result_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (core_stat.adv),
    .pair    (pair),
    .pop     (out_ready),
    .out_vld (out_valid),
    .head    (head),
    .room    (fifo_room)
  );

  // result ports
  assign out_pixel_row    = head.row;
  assign out_pixel_column = head.col;
  assign out_red          = head.red;
  assign out_green        = head.green;
  assign out_blue         = head.blue;
  assign out_alpha        = head.alpha;
  assign out_last_of_run  = head.last;

`ifndef SYNTHESIS
  // frame start puts the next pixel at column one, or column zero at width one
  a_frame_start_col: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_frame_start |=>
      col_r == (($past(w_eff) == WW'(1)) ? CW'(0) : CW'(1)))
    else $error("column counter wrong after frame start");

  // an accepted beat occupies the window stage
  a_acc_loads: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> core_stat.vld)
    else $error("accepted pixel missing from window stage");

  // input only stalls behind a held window stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> core_stat.vld && !fifo_room)
    else $error("input stalled without cause");

  // second result of a pixel follows the first directly
  a_pair_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid)
    else $error("result run broken");
`endif

endmodule
